### rtl/core/udpdmx_pkg.sv
// Package for the UDP port demultiplexer: sizes, status codes, command codes,
// transaction structs and queue addressing helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package udpdmx_pkg;

    localparam int NUM_PORTS    = 32;
    localparam int QUEUE_DEPTH  = 16;
    localparam int HANDLE_WIDTH = 16;

    localparam int IDX_W      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_DEPTH = NUM_PORTS * QUEUE_DEPTH;
    localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

    localparam logic [1:0] CMD_BIND    = 2'd0;
    localparam logic [1:0] CMD_UNBIND  = 2'd1;
    localparam logic [1:0] CMD_DELIVER = 2'd2;
    localparam logic [1:0] CMD_RECEIVE = 2'd3;

    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ALREADY  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTBOUND = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_FREED    = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] port;
        logic [7:0]  proto;
        logic [15:0] pkt_handle;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_handle;
        logic        last;
    } rsp_item_t;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } ctx_t;

    typedef struct packed {
        logic             set;
        logic             clear;
        logic [IDX_W-1:0] idx;
        logic [15:0]      port;
    } tbl_wr_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } tbl_res_t;

    function automatic logic [SLOT_AW-1:0] slot_addr(input logic [IDX_W-1:0] idx,
                                                     input logic [PTR_W-1:0] ptr);
        logic [SLOT_AW-1:0] base;
        base = SLOT_AW'(idx) * SLOT_AW'(QUEUE_DEPTH);
        return base + SLOT_AW'(ptr);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1))
            nxt = '0;
        else
            nxt = ptr + PTR_W'(1);
        return nxt;
    endfunction

endpackage
`default_nettype wire

### rtl/core/udpdmx_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module udpdmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/core/udpdmx_lookup.sv
// Bound-port table: valid bits and port numbers in flip-flops, a parallel
// match and a lowest-free-entry search, both registered. Uses udpdmx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module udpdmx_lookup (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                capture,
    input  wire logic [15:0]         key,
    input  wire udpdmx_pkg::tbl_wr_t wr,
    output udpdmx_pkg::tbl_res_t     res
);
    import udpdmx_pkg::*;

    logic [NUM_PORTS-1:0] valid_reg;
    logic [15:0]          port_reg [NUM_PORTS];
    tbl_res_t             res_reg;
    tbl_res_t             res_next;

    always_comb
    begin
        res_next = '0;
        for (int i = NUM_PORTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && port_reg[i] == key)
            begin
                res_next.hit     = 1'b1;
                res_next.hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            if (wr.set)
                valid_reg[wr.idx] <= 1'b1;
            else if (wr.clear)
                valid_reg[wr.idx] <= 1'b0;
            if (capture)
                res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.set)
            port_reg[wr.idx] <= wr.port;
    end

    assign res = res_reg;

`ifndef SYNTHESIS
    a_set_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.set && wr.clear))
        else $error("table set and clear in the same cycle");
    a_set_free_entry: assert property (@(posedge clk) disable iff (!rst_n)
        wr.set |-> !valid_reg[wr.idx])
        else $error("bind overwrote a valid entry");
    a_clear_valid_entry: assert property (@(posedge clk) disable iff (!rst_n)
        wr.clear |-> valid_reg[wr.idx])
        else $error("unbind cleared an entry that was not valid");
`endif

endmodule
`default_nettype wire

### rtl/core/udp_port_demux_queues.sv
// Top level of the UDP port demultiplexer: command sequencer, queue context
// RAM and handle RAM. Uses udpdmx_pkg, udpdmx_lookup and udpdmx_ram.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction on req is a bind, unbind, deliver or receive command and
// produces one or more transactions on rsp, the final one marked by last.
// A successful receive reads the per-entry queue context from a RAM and then
// the handle from a second RAM. Unbind of a bound port frees each pending
// handle with one read of the handle RAM. One command is in work at a time;
// a result waiting in the output register does not hold off the next
// request. There is no clearing pass after reset.
module udp_port_demux_queues (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire udpdmx_pkg::req_item_t req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output udpdmx_pkg::rsp_item_t      rsp
);
    import udpdmx_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_CTX   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_RDS   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DWAIT = 3'd6;

    logic [2:0]       state_reg, state_next;
    req_item_t        item_reg;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg;
    rsp_item_t        rsp_reg;

    tbl_wr_t          tbl_wr;
    tbl_res_t         tbl_res;

    logic             ctx_we, ctx_re;
    logic [IDX_W-1:0] ctx_waddr;
    ctx_t             ctx_wdata, ctx_rdata;

    logic               slot_we, slot_re;
    logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
    logic [15:0]        slot_rdata;

    logic      out_free;
    logic      emit;
    rsp_item_t emit_item;

    udpdmx_lookup u_lookup (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (state_reg == S_LOOK),
        .key     (item_reg.port),
        .wr      (tbl_wr),
        .res     (tbl_res)
    );

    udpdmx_ram #(
        .WIDTH ($bits(ctx_t)),
        .DEPTH (NUM_PORTS)
    ) u_ctx_ram (
        .clk   (clk),
        .we    (ctx_we),
        .waddr (ctx_waddr),
        .wdata (ctx_wdata),
        .re    (ctx_re),
        .raddr (tbl_res.hit_idx),
        .rdata (ctx_rdata)
    );

    udpdmx_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (item_reg.pkt_handle),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        tbl_wr     = '0;
        ctx_we     = 1'b0;
        ctx_re     = 1'b0;
        ctx_waddr  = tbl_res.hit_idx;
        ctx_wdata  = '0;
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        slot_waddr = slot_addr(tbl_res.hit_idx, ctx_rdata.tail);
        slot_raddr = slot_addr(tbl_res.hit_idx, ctx_rdata.head);
        emit       = 1'b0;
        emit_item  = '{status: ST_OK, out_handle: 16'd0, last: 1'b1};
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_CTX;
            end
            S_CTX:
            begin
                ctx_re     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    case (item_reg.cmd)
                        CMD_BIND:
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (tbl_res.hit)
                                emit_item.status = ST_ALREADY;
                            else if (!tbl_res.free_found)
                                emit_item.status = ST_FULL;
                            else
                            begin
                                tbl_wr.set  = 1'b1;
                                tbl_wr.idx  = tbl_res.free_idx;
                                tbl_wr.port = item_reg.port;
                                ctx_we      = 1'b1;
                                ctx_waddr   = tbl_res.free_idx;
                            end
                        end
                        CMD_UNBIND:
                        begin
                            if (tbl_res.hit)
                            begin
                                ptr_next   = ctx_rdata.head;
                                cnt_next   = ctx_rdata.count;
                                state_next = S_DRAIN;
                            end
                            else
                            begin
                                emit       = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        CMD_DELIVER:
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (item_reg.proto != PROTO_UDP || !tbl_res.hit ||
                                ctx_rdata.count >= CNT_W'(QUEUE_DEPTH))
                            begin
                                emit_item.status     = ST_DROPPED;
                                emit_item.out_handle = item_reg.pkt_handle;
                            end
                            else
                            begin
                                slot_we         = 1'b1;
                                ctx_we          = 1'b1;
                                ctx_wdata.head  = ctx_rdata.head;
                                ctx_wdata.tail  = ptr_inc(ctx_rdata.tail);
                                ctx_wdata.count = ctx_rdata.count + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            if (!tbl_res.hit)
                            begin
                                emit             = 1'b1;
                                emit_item.status = ST_NOTBOUND;
                                state_next       = S_IDLE;
                            end
                            else if (ctx_rdata.count == '0)
                            begin
                                emit             = 1'b1;
                                emit_item.status = ST_EMPTY;
                                state_next       = S_IDLE;
                            end
                            else
                            begin
                                slot_re         = 1'b1;
                                ctx_we          = 1'b1;
                                ctx_wdata.head  = ptr_inc(ctx_rdata.head);
                                ctx_wdata.tail  = ctx_rdata.tail;
                                ctx_wdata.count = ctx_rdata.count - CNT_W'(1);
                                state_next      = S_RDS;
                            end
                        end
                    endcase
                end
            end
            S_RDS:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_item.out_handle = slot_rdata;
                    state_next           = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == '0)
                begin
                    if (out_free)
                    begin
                        emit         = 1'b1;
                        tbl_wr.clear = 1'b1;
                        tbl_wr.idx   = tbl_res.hit_idx;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = slot_addr(tbl_res.hit_idx, ptr_reg);
                    state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_item.status     = ST_FREED;
                    emit_item.out_handle = slot_rdata;
                    emit_item.last       = 1'b0;
                    ptr_next             = ptr_inc(ptr_reg);
                    cnt_next             = cnt_reg - CNT_W'(1);
                    state_next           = S_DRAIN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (emit)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (req_valid && req_ready)
            item_reg <= req;
        if (emit)
            rsp_reg <= emit_item;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!rsp_valid_reg || rsp_ready))
        else $error("result register overwritten while still pending");
    a_drain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("drain count exceeds queue depth");
    a_one_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> (ctx_we && state_reg == S_EXEC))
        else $error("handle written without a context update");
    a_freed_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_item.status == ST_FREED) |-> !emit_item.last)
        else $error("freed handle marked as last");
`endif

endmodule
`default_nettype wire

### sim/tb_udp_port_demux_queues.sv
// Testbench for the UDP port demultiplexer: drives bind, unbind, deliver and
// receive commands and checks every response against a built-in predictor.
// Depends on udpdmx_pkg and udp_port_demux_queues.
`timescale 1ns / 1ps
module tb_udp_port_demux_queues;
    import udpdmx_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    rsp_item_t   expected_rsp_q[$];
    logic        bound_valid[NUM_PORTS];
    logic [15:0] bound_port[NUM_PORTS];
    logic [15:0] port_queue[NUM_PORTS][$];
    logic [15:0] port_pool[$];

    udp_port_demux_queues dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int find_entry(logic [15:0] p);
        for (int i = 0; i < NUM_PORTS; i++)
            if (bound_valid[i] && bound_port[i] == p)
                return i;
        return -1;
    endfunction

    function automatic rsp_item_t make_rsp(logic [2:0] st, logic [15:0] h, logic l);
        rsp_item_t r;
        r.status = st;
        r.out_handle = h;
        r.last = l;
        return r;
    endfunction

    task automatic predict_demux(req_item_t t);
        int e;
        int f;
        e = find_entry(t.port);
        case (t.cmd)
            CMD_BIND:
            begin
                f = -1;
                for (int i = NUM_PORTS - 1; i >= 0; i--)
                    if (!bound_valid[i])
                        f = i;
                if (e >= 0)
                    expected_rsp_q.push_back(make_rsp(ST_ALREADY, '0, 1'b1));
                else if (f < 0)
                    expected_rsp_q.push_back(make_rsp(ST_FULL, '0, 1'b1));
                else
                begin
                    bound_valid[f] = 1'b1;
                    bound_port[f] = t.port;
                    port_queue[f].delete();
                    expected_rsp_q.push_back(make_rsp(ST_OK, '0, 1'b1));
                end
            end
            CMD_UNBIND:
            begin
                if (e >= 0)
                begin
                    foreach (port_queue[e][k])
                        expected_rsp_q.push_back(make_rsp(ST_FREED, port_queue[e][k], 1'b0));
                    port_queue[e].delete();
                    bound_valid[e] = 1'b0;
                    bound_port[e] = '0;
                end
                expected_rsp_q.push_back(make_rsp(ST_OK, '0, 1'b1));
            end
            CMD_DELIVER:
            begin
                if (t.proto != PROTO_UDP || e < 0 || port_queue[e].size() >= QUEUE_DEPTH)
                    expected_rsp_q.push_back(make_rsp(ST_DROPPED, t.pkt_handle, 1'b1));
                else
                begin
                    port_queue[e].push_back(t.pkt_handle);
                    expected_rsp_q.push_back(make_rsp(ST_OK, '0, 1'b1));
                end
            end
            default:
            begin
                if (e < 0)
                    expected_rsp_q.push_back(make_rsp(ST_NOTBOUND, '0, 1'b1));
                else if (port_queue[e].size() == 0)
                    expected_rsp_q.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
                else
                    expected_rsp_q.push_back(make_rsp(ST_OK, port_queue[e].pop_front(), 1'b1));
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_command(logic [1:0] c, logic [15:0] p, logic [7:0] pr, logic [15:0] h);
        req_item_t t;
        t.cmd = c;
        t.port = p;
        t.proto = pr;
        t.pkt_handle = h;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req <= t;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_demux(t);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch("unexpected transaction", rsp.out_handle, 16'd0);
                else
                begin
                    rsp_item_t w;
                    w = expected_rsp_q.pop_front();
                    if (rsp.status !== w.status)
                        report_mismatch("status", 16'(rsp.status), 16'(w.status));
                    if (rsp.out_handle !== w.out_handle)
                        report_mismatch("out_handle", rsp.out_handle, w.out_handle);
                    if (rsp.last !== w.last)
                        report_mismatch("last", 16'(rsp.last), 16'(w.last));
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick_port();
        if (port_pool.size() == 0 || $urandom_range(9) == 0)
            return 16'($urandom);
        return port_pool[$urandom_range(port_pool.size() - 1)];
    endfunction

    task automatic test_directed_edges();
        send_command(CMD_RECEIVE, 16'hFFFF, 8'd0, 16'hFFFF);
        send_command(CMD_UNBIND, 16'd0, 8'd0, 16'd0);
        send_command(CMD_BIND, 16'd0, 8'hFF, 16'hFFFF);
        send_command(CMD_BIND, 16'd0, 8'd0, 16'd0);
        send_command(CMD_BIND, 16'hFFFF, 8'd0, 16'd0);
        send_command(CMD_RECEIVE, 16'hFFFF, 8'd0, 16'd0);
        send_command(CMD_DELIVER, 16'hFFFF, 8'd16, 16'hFFFF);
        send_command(CMD_DELIVER, 16'h1234, PROTO_UDP, 16'hAAAA);
        send_command(CMD_DELIVER, 16'hFFFF, PROTO_UDP, 16'hFFFF);
        send_command(CMD_DELIVER, 16'hFFFF, PROTO_UDP, 16'h0000);
        send_command(CMD_DELIVER, 16'hFFFF, PROTO_UDP, 16'h5555);
        send_command(CMD_RECEIVE, 16'hFFFF, 8'd0, 16'd0);
        send_command(CMD_UNBIND, 16'hFFFF, 8'd0, 16'd0);
        send_command(CMD_UNBIND, 16'd0, 8'd0, 16'd0);
    endtask

    task automatic test_table_full();
        for (int i = 0; i <= NUM_PORTS; i++)
            send_command(CMD_BIND, 16'(100 + i), 8'd0, 16'd0);
        send_command(CMD_BIND, 16'd100, 8'd0, 16'd0);
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_command(CMD_DELIVER, 16'd105, PROTO_UDP, 16'(16'hC000 + i));
        send_command(CMD_UNBIND, 16'd105, 8'd0, 16'd0);
        for (int i = 0; i < NUM_PORTS; i++)
            send_command(CMD_UNBIND, 16'(100 + i), 8'd0, 16'd0);
    endtask

    task automatic test_random_traffic(int n);
        logic [1:0] c;
        int r;
        port_pool.delete();
        for (int i = 0; i < 12; i++)
            port_pool.push_back(16'($urandom));
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            c = (r < 12) ? CMD_BIND : (r < 20) ? CMD_UNBIND : (r < 65) ? CMD_DELIVER
                : CMD_RECEIVE;
            send_command(c, pick_port(),
                         ($urandom_range(7) == 0) ? 8'($urandom) : PROTO_UDP,
                         16'($urandom));
        end
        foreach (port_pool[k])
            send_command(CMD_UNBIND, port_pool[k], 8'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            bound_valid[i] = 1'b0;
            bound_port[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 12;
        recv_idle_pct = 56;
        test_directed_edges();
        test_table_full();
        test_random_traffic(92);
        send_idle_pct = 56;
        recv_idle_pct = 12;
        test_random_traffic(92);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(92);
        req_valid <= 1'b0;
        wait_drained();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
